// ===== rtl/ssbg_pkg.sv =====
// Shared types and constants for the spectral subtraction bin gain block.
package ssbg_pkg;

    // Fixed field widths of the transaction payload.
    localparam int BIN_PORT_W = 8;
    localparam int MAG_PORT_W = 24;
    localparam int SPEC_W     = 24;
    localparam int GAIN_W     = 16;
    localparam int SCALE_W    = 8;
    localparam int PERIOD_W   = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Four rotating period minima per bin.
    localparam int SLOT_COUNT = 4;
    localparam int SLOT_W     = 2;

    // Quotient bits of the noise to magnitude ratio in Q1.15.
    localparam int Q_BITS = 15;
    localparam logic [GAIN_W-1:0] ONE_Q15 = 16'h8000;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_SCALE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_FLOOR        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_PER_PERIOD = 2'd2;

    // Register values after reset.
    localparam logic [SCALE_W-1:0]  RST_NOISE_SCALE       = 8'd20;
    localparam logic [GAIN_W-1:0]   RST_GAIN_FLOOR        = 16'd3277;
    localparam logic [PERIOD_W-1:0] RST_FRAMES_PER_PERIOD = 10'd78;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_REDUCE,
        S_UPDATE,
        S_MIN,
        S_MUL_NOISE,
        S_SAT,
        S_DIVCHK,
        S_DIV,
        S_MUL_RE,
        S_MUL_IM,
        S_DONE
    } t_state;

endpackage

// ===== rtl/ssbg_divider.sv =====
// Iterative restoring divider giving the Q1.15 noise to magnitude ratio.
module ssbg_divider #(
    parameter int MAG_BITS = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [MAG_BITS-1:0]          i_dividend,
    input  logic [MAG_BITS-1:0]          i_divisor,
    output logic                         o_busy,
    output logic                         o_done,
    output logic [ssbg_pkg::Q_BITS-1:0]  o_quotient
);
    import ssbg_pkg::*;

    localparam int CNT_W = $clog2(Q_BITS + 1);

    logic [MAG_BITS-1:0] r_rem;
    logic [MAG_BITS-1:0] r_div;
    logic [Q_BITS-1:0]   r_quot;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [MAG_BITS:0]   w_shift;
    logic [MAG_BITS:0]   w_diff;
    logic                w_take;

    // The dividend is always below the divisor, so the remainder stays in MAG_BITS.
    assign w_shift = {r_rem, 1'b0};
    assign w_take  = (w_shift >= {1'b0, r_div});
    assign w_diff  = w_shift - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(Q_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_dividend;
            r_div  <= i_divisor;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= w_take ? w_diff[MAG_BITS-1:0] : w_shift[MAG_BITS-1:0];
            r_quot <= {r_quot[Q_BITS-2:0], w_take};
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quot;

endmodule

// ===== rtl/ssbg_min_store.sv =====
// Per-bin store of the four period minima, one row per bin, with a clearing pass after reset.
module ssbg_min_store #(
    parameter int BIN_COUNT = 256,
    parameter int MAG_BITS  = 24
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_rd_en,
    input  logic                                        i_wr_en,
    input  logic [$clog2(BIN_COUNT)-1:0]                i_addr,
    input  logic [ssbg_pkg::SLOT_COUNT*MAG_BITS-1:0]    i_wr_data,
    output logic [ssbg_pkg::SLOT_COUNT*MAG_BITS-1:0]    o_rd_data,
    output logic                                        o_clearing
);
    import ssbg_pkg::*;

    localparam int ROW_W  = SLOT_COUNT * MAG_BITS;
    localparam int ADDR_W = $clog2(BIN_COUNT);

    logic [ROW_W-1:0]  mem [BIN_COUNT];
    logic [ROW_W-1:0]  r_rd_data;
    logic [ADDR_W-1:0] r_clr_addr;
    logic              r_clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
            if (r_clr_addr == ADDR_W'(BIN_COUNT - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            mem[i_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clearing;

endmodule

// ===== rtl/ssbg_mul.sv =====
// Shared signed multiplier with a registered product.
module ssbg_mul #(
    parameter int A_W = 25,
    parameter int B_W = 17
) (
    input  logic                      i_clk,
    input  logic signed [A_W-1:0]     i_a,
    input  logic signed [B_W-1:0]     i_b,
    output logic signed [A_W+B_W-1:0] o_prod
);
    logic signed [A_W+B_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

// ===== rtl/spectral_subtraction_bin_gain.sv =====
// Top level: per-bin spectral subtraction gain with minimum-statistics noise tracking.
// Steps from an accepted transaction to o_valid: the bin index is brought below BIN_COUNT by
// subtraction (none needed when BIN_COUNT >= 256), then come the store update, the minimum search,
// the noise multiply, the divider (skipped when noise is at least the magnitude) and the output multiplies.
// Throughput: one transaction at a time; the next is taken only after the result is loaded.
// Reset: synchronous, active low; the minimum store is then cleared row by row.
module spectral_subtraction_bin_gain #(
    parameter int BIN_COUNT = 256,
    parameter int MAG_BITS  = 24
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic [ssbg_pkg::BIN_PORT_W-1:0]         i_bin_index,
    input  logic [ssbg_pkg::MAG_PORT_W-1:0]         i_magnitude,
    input  logic signed [ssbg_pkg::SPEC_W-1:0]      i_spec_real,
    input  logic signed [ssbg_pkg::SPEC_W-1:0]      i_spec_imag,
    input  logic                                    i_frame_end,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic signed [ssbg_pkg::SPEC_W-1:0]      o_scaled_real,
    output logic signed [ssbg_pkg::SPEC_W-1:0]      o_scaled_imag,
    output logic [ssbg_pkg::GAIN_W-1:0]             o_bin_gain,
    output logic [ssbg_pkg::MAG_PORT_W-1:0]         o_noise_level,
    input  logic                                    i_cfg_we,
    input  logic [ssbg_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [ssbg_pkg::CFG_DATA_W-1:0]         i_cfg_data
);
    import ssbg_pkg::*;

    localparam int BIN_W   = $clog2(BIN_COUNT);
    localparam int CMP_W   = ((BIN_W + 1) > BIN_PORT_W) ? (BIN_W + 1) : BIN_PORT_W;
    localparam int ROW_W   = SLOT_COUNT * MAG_BITS;
    localparam int MUL_A_W = ((MAG_BITS > SPEC_W) ? MAG_BITS : SPEC_W) + 1;
    localparam int MUL_B_W = GAIN_W + 1;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam logic [MAG_BITS-1:0] MAG_MAX = {MAG_BITS{1'b1}};

    // Sequencer state and control.
    t_state r_state;
    t_state n_state;
    logic   w_rd_en;
    logic   w_wr_en;
    logic   w_div_start;
    logic   w_load_out;

    // Configuration registers.
    logic [SCALE_W-1:0]  r_noise_scale;
    logic [GAIN_W-1:0]   r_gain_floor;
    logic [PERIOD_W-1:0] r_frames_per_period;

    // Period tracking.
    logic [PERIOD_W-1:0] r_period_cnt;
    logic [SLOT_W-1:0]   r_newest_slot;
    logic [PERIOD_W-1:0] w_period;
    logic [PERIOD_W-1:0] w_cnt_inc;
    logic                w_rollover;

    // Captured transaction.
    logic [BIN_PORT_W-1:0]     r_bin_raw;
    logic [MAG_BITS-1:0]       r_mag;
    logic signed [SPEC_W-1:0]  r_re;
    logic signed [SPEC_W-1:0]  r_im;
    logic                      r_last;

    // Working registers.
    logic [ROW_W-1:0]     r_row;
    logic [MAG_BITS-1:0]  r_least;
    logic [SLOT_W-1:0]    r_min_idx;
    logic [MAG_BITS-1:0]  r_noise;
    logic [GAIN_W-1:0]    r_gain;
    logic [SPEC_W-1:0]    r_scaled_re;

    // Output register.
    logic                 r_out_valid;
    logic [SPEC_W-1:0]    r_out_real;
    logic [SPEC_W-1:0]    r_out_imag;
    logic [GAIN_W-1:0]    r_out_gain;
    logic [MAG_PORT_W-1:0] r_out_noise;
    logic                 w_out_free;

    // Store, divider and multiplier connections.
    logic [BIN_W-1:0]     w_bin_addr;
    logic                 w_bin_big;
    logic [ROW_W-1:0]     w_rd_row;
    logic [ROW_W-1:0]     w_upd_row;
    logic [MAG_BITS-1:0]  w_old_min;
    logic [MAG_BITS-1:0]  w_new_min;
    logic [MAG_BITS-1:0]  w_min_cand;
    logic                 w_clearing;
    logic                 w_div_busy;
    logic                 w_div_done;
    logic [Q_BITS-1:0]    w_quot;
    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [MUL_P_W-1:0] w_prod;
    logic [MAG_BITS-1:0]  w_noise_sat;
    logic [GAIN_W-1:0]    w_floor_g;
    logic [GAIN_W-1:0]    w_raw_gain;
    logic [GAIN_W-1:0]    w_div_gain;

    // The bin index is brought below BIN_COUNT by repeated subtraction, one step a cycle.
    assign w_bin_big  = (CMP_W'(r_bin_raw) >= CMP_W'(BIN_COUNT));
    assign w_bin_addr = BIN_W'(r_bin_raw);

    // Tracking update of the newest slot: overwrite at the start of a period, else keep the least.
    assign w_old_min = w_rd_row[int'(r_newest_slot)*MAG_BITS +: MAG_BITS];
    assign w_new_min = ((r_period_cnt == '0) || (r_mag < w_old_min)) ? r_mag : w_old_min;

    always_comb begin
        w_upd_row = w_rd_row;
        w_upd_row[int'(r_newest_slot)*MAG_BITS +: MAG_BITS] = w_new_min;
    end

    // The slots after the first are compared one per cycle against the running least, which starts at slot 0.
    assign w_min_cand = r_row[int'(r_min_idx)*MAG_BITS +: MAG_BITS];

    // The product is never negative here, so any bit above MAG_BITS means saturation.
    assign w_noise_sat = (|w_prod[MUL_P_W-1:MAG_BITS]) ? MAG_MAX : w_prod[MAG_BITS-1:0];

    // A floor above one is held at one; the gain never drops below the floor.
    assign w_floor_g  = (r_gain_floor > ONE_Q15) ? ONE_Q15 : r_gain_floor;
    assign w_raw_gain = ONE_Q15 - GAIN_W'(w_quot);
    assign w_div_gain = (w_raw_gain > w_floor_g) ? w_raw_gain : w_floor_g;

    // Frame end bookkeeping: a zero period length acts as one, and a count that wraps ends it.
    assign w_period   = (r_frames_per_period == '0) ? PERIOD_W'(1) : r_frames_per_period;
    assign w_cnt_inc  = r_period_cnt + PERIOD_W'(1);
    assign w_rollover = (w_cnt_inc >= w_period) || (w_cnt_inc == '0);

    // The output register may be reloaded in the cycle its transaction is taken.
    assign w_out_free = !r_out_valid || i_ready;

    // Operand selection for the shared multiplier. Outside the noise and real-part steps it
    // works on the imaginary part, so the product is still there when the result is loaded.
    always_comb begin
        case (r_state)
            S_MUL_NOISE: begin
                w_mul_a = MUL_A_W'(r_least);
                w_mul_b = MUL_B_W'(r_noise_scale);
            end
            S_MUL_RE: begin
                w_mul_a = MUL_A_W'(r_re);
                w_mul_b = MUL_B_W'(r_gain);
            end
            default: begin
                w_mul_a = MUL_A_W'(r_im);
                w_mul_b = MUL_B_W'(r_gain);
            end
        endcase
    end

    ssbg_min_store #(
        .BIN_COUNT (BIN_COUNT),
        .MAG_BITS  (MAG_BITS)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (w_rd_en),
        .i_wr_en    (w_wr_en),
        .i_addr     (w_bin_addr),
        .i_wr_data  (w_upd_row),
        .o_rd_data  (w_rd_row),
        .o_clearing (w_clearing)
    );

    ssbg_divider #(
        .MAG_BITS (MAG_BITS)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_noise),
        .i_divisor  (r_mag),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    ssbg_mul #(
        .A_W (MUL_A_W),
        .B_W (MUL_B_W)
    ) u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // Sequencer: one transaction goes through the store, the compare loop, the multiplier,
    // the divider when it is needed and the multiplier again before the next one is accepted.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        w_rd_en     = 1'b0;
        w_wr_en     = 1'b0;
        w_div_start = 1'b0;
        w_load_out  = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                if (!w_clearing) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_REDUCE;
                end
            end
            S_REDUCE: begin
                if (!w_bin_big) begin
                    w_rd_en = 1'b1;
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                w_wr_en = 1'b1;
                n_state = S_MIN;
            end
            S_MIN: begin
                if (r_min_idx == SLOT_W'(SLOT_COUNT - 1)) begin
                    n_state = S_MUL_NOISE;
                end
            end
            S_MUL_NOISE: begin
                n_state = S_SAT;
            end
            S_SAT: begin
                n_state = S_DIVCHK;
            end
            S_DIVCHK: begin
                // Zero magnitude and noise at or above the magnitude both give the floor.
                if (r_noise >= r_mag) begin
                    n_state = S_MUL_RE;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_MUL_RE;
                end
            end
            S_MUL_RE: begin
                n_state = S_MUL_IM;
            end
            S_MUL_IM: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Control registers: configuration, period tracking and the output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_noise_scale       <= RST_NOISE_SCALE;
            r_gain_floor        <= RST_GAIN_FLOOR;
            r_frames_per_period <= RST_FRAMES_PER_PERIOD;
            r_period_cnt        <= '0;
            r_newest_slot       <= '0;
            r_out_valid         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_NOISE_SCALE:       r_noise_scale       <= i_cfg_data[SCALE_W-1:0];
                    CFG_GAIN_FLOOR:        r_gain_floor        <= i_cfg_data[GAIN_W-1:0];
                    CFG_FRAMES_PER_PERIOD: r_frames_per_period <= i_cfg_data[PERIOD_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
                if (r_last) begin
                    if (w_rollover) begin
                        r_period_cnt  <= '0;
                        r_newest_slot <= r_newest_slot + SLOT_W'(1);
                    end else begin
                        r_period_cnt <= w_cnt_inc;
                    end
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    r_bin_raw <= i_bin_index;
                    r_mag     <= MAG_BITS'(i_magnitude);
                    r_re      <= i_spec_real;
                    r_im      <= i_spec_imag;
                    r_last    <= i_frame_end;
                end
            end
            S_REDUCE: begin
                if (w_bin_big) begin
                    r_bin_raw <= r_bin_raw - BIN_PORT_W'(BIN_COUNT);
                end
            end
            S_UPDATE: begin
                r_row     <= w_upd_row;
                r_least   <= w_upd_row[MAG_BITS-1:0];
                r_min_idx <= SLOT_W'(1);
            end
            S_MIN: begin
                if (w_min_cand < r_least) begin
                    r_least <= w_min_cand;
                end
                r_min_idx <= r_min_idx + SLOT_W'(1);
            end
            S_SAT: begin
                r_noise <= w_noise_sat;
            end
            S_DIVCHK: begin
                if (r_noise >= r_mag) begin
                    r_gain <= w_floor_g;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    r_gain <= w_div_gain;
                end
            end
            S_MUL_IM: begin
                // Arithmetic shift by 15 of the real-part product, truncated to the field.
                r_scaled_re <= w_prod[SPEC_W+Q_BITS-1:Q_BITS];
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_out_real  <= r_scaled_re;
                    r_out_imag  <= w_prod[SPEC_W+Q_BITS-1:Q_BITS];
                    r_out_gain  <= r_gain;
                    r_out_noise <= MAG_PORT_W'(r_noise);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_scaled_real = r_out_real;
    assign o_scaled_imag = r_out_imag;
    assign o_bin_gain    = r_out_gain;
    assign o_noise_level = r_out_noise;

    // No transaction may be taken while the minimum store is still being cleared.
    a_no_accept_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |-> !w_clearing)
        else $error("transaction accepted during the clearing pass");

    // The divider is only started when it is free.
    a_div_free_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_busy)
        else $error("divider started while busy");

    // The gain applied to the spectrum lies between the clamped floor and one.
    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL_RE) |-> ((r_gain <= ONE_Q15) && (r_gain >= w_floor_g)))
        else $error("bin gain out of range");

    // The store is addressed only with a reduced bin index.
    a_bin_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE) |-> (CMP_W'(r_bin_raw) < CMP_W'(BIN_COUNT)))
        else $error("bin index not reduced below the bin count");

    // A new result only appears after the sequencer has finished a transaction.
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result loaded outside the final step");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the spectral subtraction bin gain block.
`timescale 1ns / 1ps

module tb;
    import ssbg_pkg::*;

    localparam int BIN_COUNT     = 256;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 40;

    // The fourth index on the configuration port decodes to no register.
    localparam logic [CFG_IDX_W-1:0] CFG_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [BIN_PORT_W-1:0] bin_index;
        logic [MAG_PORT_W-1:0] magnitude;
        logic [SPEC_W-1:0]     spec_real;
        logic [SPEC_W-1:0]     spec_imag;
        logic                  frame_end;
    } t_bin_item;

    typedef struct packed {
        logic [SPEC_W-1:0]     scaled_real;
        logic [SPEC_W-1:0]     scaled_imag;
        logic [GAIN_W-1:0]     bin_gain;
        logic [MAG_PORT_W-1:0] noise_level;
    } t_bin_result;

    // Every input starts at a known value.
    logic                         i_clk        = 1'b0;
    logic                         i_rst_n      = 1'b0;
    logic                         i_valid      = 1'b0;
    logic                         o_ready;
    logic [BIN_PORT_W-1:0]        i_bin_index  = '0;
    logic [MAG_PORT_W-1:0]        i_magnitude  = '0;
    logic signed [SPEC_W-1:0]     i_spec_real  = '0;
    logic signed [SPEC_W-1:0]     i_spec_imag  = '0;
    logic                         i_frame_end  = 1'b0;
    logic                         o_valid;
    logic                         i_ready      = 1'b0;
    logic signed [SPEC_W-1:0]     o_scaled_real;
    logic signed [SPEC_W-1:0]     o_scaled_imag;
    logic [GAIN_W-1:0]            o_bin_gain;
    logic [MAG_PORT_W-1:0]        o_noise_level;
    logic                         i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]         i_cfg_index  = '0;
    logic [CFG_DATA_W-1:0]        i_cfg_data   = '0;

    spectral_subtraction_bin_gain #(
        .BIN_COUNT(BIN_COUNT),
        .MAG_BITS (MAG_PORT_W)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_bin_index  (i_bin_index),
        .i_magnitude  (i_magnitude),
        .i_spec_real  (i_spec_real),
        .i_spec_imag  (i_spec_imag),
        .i_frame_end  (i_frame_end),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_scaled_real(o_scaled_real),
        .o_scaled_imag(o_scaled_imag),
        .o_bin_gain   (o_bin_gain),
        .o_noise_level(o_noise_level),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Bins waiting to be offered, and results the block still owes us.
    t_bin_item   bins_to_send[$];
    t_bin_result scaled_bins_due[$];
    t_bin_item   offered_bin;
    bit          bin_taken = 1'b0;

    // Handshake pacing, set per section by the stimulus sequence.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_token    = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    int fail_count     = 0;
    int mismatch_count = 0;
    int stuck_cycles   = 0;

    // Our own copy of the tracking state and the registers.
    logic [MAG_PORT_W-1:0] slot_minima [SLOT_COUNT][BIN_COUNT];
    logic [SLOT_W-1:0]     newest_slot_q  = '0;
    logic [PERIOD_W-1:0]   frame_count_q  = '0;
    logic [SCALE_W-1:0]    noise_scale_q  = RST_NOISE_SCALE;
    logic [GAIN_W-1:0]     gain_floor_q   = RST_GAIN_FLOOR;
    logic [PERIOD_W-1:0]   period_q       = RST_FRAMES_PER_PERIOD;

    // Works out the result of one accepted bin and advances the tracking state.
    task automatic predict_bin_gain(input t_bin_item it);
        logic [BIN_PORT_W-1:0] b;
        logic [MAG_PORT_W-1:0] mag;
        logic [MAG_PORT_W-1:0] least;
        logic [63:0]           noise;
        logic [63:0]           ratio;
        logic [GAIN_W-1:0]     floor_g;
        logic [GAIN_W-1:0]     raw;
        logic [GAIN_W-1:0]     gain;
        logic [PERIOD_W-1:0]   period;
        longint                re;
        longint                im;
        longint                g;
        t_bin_result           r;
        b   = it.bin_index;
        mag = it.magnitude;
        // On the first frame of a period the newest minimum is simply overwritten.
        if (frame_count_q == 0 || mag < slot_minima[newest_slot_q][b]) begin
            slot_minima[newest_slot_q][b] = mag;
        end
        least = slot_minima[0][b];
        for (int s = 1; s < SLOT_COUNT; s++) begin
            if (slot_minima[s][b] < least) begin
                least = slot_minima[s][b];
            end
        end
        noise = 64'(least) * 64'(noise_scale_q);
        if (noise > 64'hFF_FFFF) begin
            noise = 64'hFF_FFFF;
        end
        floor_g = (gain_floor_q > ONE_Q15) ? ONE_Q15 : gain_floor_q;
        if (mag == 0) begin
            gain = floor_g;
        end else begin
            ratio = (noise << Q_BITS) / 64'(mag);
            raw   = (ratio >= 64'(ONE_Q15)) ? '0 : ONE_Q15 - ratio[GAIN_W-1:0];
            gain  = (raw > floor_g) ? raw : floor_g;
        end
        if (it.frame_end) begin
            period        = (period_q == 0) ? PERIOD_W'(1) : period_q;
            frame_count_q = frame_count_q + PERIOD_W'(1);
            if (frame_count_q >= period || frame_count_q == 0) begin
                frame_count_q = '0;
                newest_slot_q = newest_slot_q + SLOT_W'(1);
            end
        end
        g  = longint'(gain);
        re = longint'(signed'(it.spec_real));
        im = longint'(signed'(it.spec_imag));
        // An arithmetic shift gives the floor of the Q1.15 product.
        r.scaled_real = SPEC_W'((re * g) >>> Q_BITS);
        r.scaled_imag = SPEC_W'((im * g) >>> Q_BITS);
        r.bin_gain    = gain;
        r.noise_level = noise[MAG_PORT_W-1:0];
        scaled_bins_due.push_back(r);
    endtask

    // Driver: a new bin is presented at the falling edge once the last one has gone.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || bin_taken)) begin
            bin_taken = 1'b0;
            if (bins_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                offered_bin = bins_to_send.pop_front();
                i_bin_index <= offered_bin.bin_index;
                i_magnitude <= offered_bin.magnitude;
                i_spec_real <= offered_bin.spec_real;
                i_spec_imag <= offered_bin.spec_imag;
                i_frame_end <= offered_bin.frame_end;
                i_valid     <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure, with a long hold-off whenever one is requested.
    always @(negedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= i_rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: predicts on each input transaction and checks each output transaction.
    always @(posedge i_clk) begin
        t_bin_result got;
        t_bin_result want;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                predict_bin_gain(offered_bin);
                bin_taken = 1'b1;
            end
            if (o_valid && i_ready) begin
                got.scaled_real = o_scaled_real;
                got.scaled_imag = o_scaled_imag;
                got.bin_gain    = o_bin_gain;
                got.noise_level = o_noise_level;
                if (scaled_bins_due.size() == 0) begin
                    fail_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("unexpected result: real %0d imag %0d gain %0d noise %0d",
                                 $signed(got.scaled_real), $signed(got.scaled_imag),
                                 got.bin_gain, got.noise_level);
                    end
                end else begin
                    want = scaled_bins_due.pop_front();
                    if (got.scaled_real !== want.scaled_real ||
                        got.scaled_imag !== want.scaled_imag ||
                        got.bin_gain    !== want.bin_gain    ||
                        got.noise_level !== want.noise_level) begin
                        fail_count++;
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display({"mismatch (expected/actual): real %0d/%0d imag %0d/%0d",
                                      " gain %0d/%0d noise %0d/%0d"},
                                     $signed(want.scaled_real), $signed(got.scaled_real),
                                     $signed(want.scaled_imag), $signed(got.scaled_imag),
                                     want.bin_gain, got.bin_gain,
                                     want.noise_level, got.noise_level);
                        end
                    end
                end
            end
        end
    end

    // Watchdog: ends the run if no transaction moves for too long.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
        end
        if (stuck_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic t_bin_item make_bin(input logic [31:0] b, input logic [31:0] mag,
                                           input logic [31:0] re, input logic [31:0] im,
                                           input bit fe);
        t_bin_item it;
        it.bin_index = b[BIN_PORT_W-1:0];
        it.magnitude = mag[MAG_PORT_W-1:0];
        it.spec_real = re[SPEC_W-1:0];
        it.spec_imag = im[SPEC_W-1:0];
        it.frame_end = fe;
        return it;
    endfunction

    // Magnitudes spread over many octaves so that gains land all over their range.
    function automatic logic [MAG_PORT_W-1:0] rand_magnitude();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 4) begin
            return '0;
        end else if (sel < 8) begin
            return '1;
        end else if (sel < 16) begin
            return MAG_PORT_W'($urandom());
        end
        return MAG_PORT_W'($urandom_range(1, 255) << $urandom_range(0, 16));
    endfunction

    function automatic logic [SPEC_W-1:0] rand_part();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 3) begin
            return 24'h80_0000;
        end else if (sel < 6) begin
            return 24'h7F_FFFF;
        end
        return SPEC_W'($urandom());
    endfunction

    // Mostly well-formed frames over a small window of bins, so that minima build up
    // across frames and the slots rotate; the rest are stray bins with a random mark.
    task automatic queue_traffic(input int count);
        int left;
        int len;
        int window;
        left = count;
        while (left > 0) begin
            if ($urandom_range(0, 99) < 85) begin
                len    = $urandom_range(1, 12);
                len    = (len > left) ? left : len;
                window = $urandom_range(0, 7);
                for (int k = 0; k < len; k++) begin
                    bins_to_send.push_back(make_bin(window + k, rand_magnitude(), rand_part(),
                                                    rand_part(), k == len - 1));
                end
                left -= len;
            end else begin
                bins_to_send.push_back(make_bin($urandom_range(0, 255), rand_magnitude(),
                                                rand_part(), rand_part(),
                                                1'($urandom_range(0, 1))));
                left--;
            end
        end
    endtask

    // Waits until every queued bin has been sent and every result has come back.
    task automatic wait_drained();
        while (bins_to_send.size() != 0 || i_valid || scaled_bins_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Writes one register while the block is idle and mirrors it in our copy.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CFG_NOISE_SCALE: begin
                noise_scale_q = data[SCALE_W-1:0];
            end
            CFG_GAIN_FLOOR: begin
                gain_floor_q = data[GAIN_W-1:0];
            end
            CFG_FRAMES_PER_PERIOD: begin
                period_q = data[PERIOD_W-1:0];
            end
            default: begin
            end
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_phase(input int scale, input int floor_q15, input int period);
        wait_drained();
        write_reg(CFG_NOISE_SCALE, CFG_DATA_W'(scale));
        write_reg(CFG_GAIN_FLOOR, CFG_DATA_W'(floor_q15));
        write_reg(CFG_FRAMES_PER_PERIOD, CFG_DATA_W'(period));
    endtask

    initial begin
        for (int s = 0; s < SLOT_COUNT; s++) begin
            for (int b = 0; b < BIN_COUNT; b++) begin
                slot_minima[s][b] = '0;
            end
        end
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, first section with the reset register values: zero and
        // full-scale magnitude, the extreme real and imaginary parts, both edge bins.
        send_idle_pct = 36;
        recv_idle_pct = 50;
        bins_to_send.push_back(make_bin(0, 0, 24'h7F_FFFF, 24'h80_0000, 1'b0));
        bins_to_send.push_back(make_bin(255, 24'hFF_FFFF, 24'h80_0000, 24'h7F_FFFF, 1'b1));
        bins_to_send.push_back(make_bin(3, 1000, 24'hFF_FFFF, 1, 1'b0));
        bins_to_send.push_back(make_bin(3, 500, 0, 24'hFF_FFFF, 1'b1));

        // One frame per period: every frame end rotates the slots, so one bin fills
        // all four minima quickly and the noise overtakes the magnitude.
        set_phase(RST_NOISE_SCALE, RST_GAIN_FLOOR, 1);
        bins_to_send.push_back(make_bin(5, 1000, 24'h12_3456, 24'hED_CBA9, 1'b1));
        bins_to_send.push_back(make_bin(5, 2000, 24'h40_0000, 24'hC0_0000, 1'b1));
        bins_to_send.push_back(make_bin(5, 3000, 24'h7F_FFFF, 24'h80_0000, 1'b1));
        bins_to_send.push_back(make_bin(5, 4000, 24'h00_8000, 24'hFF_8000, 1'b1));
        bins_to_send.push_back(make_bin(5, 40000, 24'h55_5555, 24'hAA_AAAA, 1'b1));
        bins_to_send.push_back(make_bin(5, 100000, 24'h7F_FFFF, 24'h80_0000, 1'b1));
        bins_to_send.push_back(make_bin(5, 0, 24'h7F_FFFF, 24'h80_0000, 1'b1));
        bins_to_send.push_back(make_bin(5, 1, 24'h7F_FFFF, 24'h80_0000, 1'b0));

        // Largest multiplier with no floor; a zero minimum is still held, so the noise stays at zero.
        set_phase(255, 0, 1);
        bins_to_send.push_back(make_bin(5, 24'hFF_FFFF, 24'h7F_FFFF, 24'h80_0000, 1'b1));
        bins_to_send.push_back(make_bin(5, 1, 24'h7F_FFFF, 24'h80_0000, 1'b1));

        // A floor above one is held at one, a write to the unused index changes
        // nothing, and a zero period length behaves as a single frame.
        set_phase(1, 16'hFFFF, 0);
        write_reg(CFG_UNKNOWN, 16'h1234);
        bins_to_send.push_back(make_bin(7, 5000, 24'h7F_FFFF, 24'h80_0000, 1'b1));
        bins_to_send.push_back(make_bin(7, 300, 24'h00_0001, 24'hFF_FFFF, 1'b1));
        bins_to_send.push_back(make_bin(7, 24'hFF_FFFF, 24'h80_0001, 24'h7F_FFFE, 1'b0));

        // Zero multiplier: no noise at all, so the gain is one wherever the magnitude is not zero.
        set_phase(0, 0, 0);
        bins_to_send.push_back(make_bin(7, 12345, 24'h7F_FFFF, 24'h80_0000, 1'b1));
        bins_to_send.push_back(make_bin(128, 0, 24'h80_0000, 24'h7F_FFFF, 1'b1));

        // Random traffic with the sender idling less than the receiver.
        set_phase(RST_NOISE_SCALE, RST_GAIN_FLOOR, 3);
        queue_traffic(250);
        set_phase(255, 0, 1);
        queue_traffic(200);

        // Now the receiver idles less than the sender.
        wait_drained();
        send_idle_pct = 50;
        recv_idle_pct = 36;
        set_phase(0, ONE_Q15, 1023);
        queue_traffic(150);

        // The receiver holds off for a long stretch while bins keep coming, so the
        // block fills up and has to stall its input.
        set_phase(2, 16384, 10);
        queue_traffic(200);
        hold_token++;

        // Shortened period: push the frame count well past two, then cut the period
        // to two so that it ends at the very next frame end.
        wait_drained();
        write_reg(CFG_FRAMES_PER_PERIOD, CFG_DATA_W'(1023));
        for (int k = 0; k < 5; k++) begin
            bins_to_send.push_back(make_bin(k, rand_magnitude(), rand_part(), rand_part(), 1'b1));
        end
        wait_drained();
        write_reg(CFG_FRAMES_PER_PERIOD, CFG_DATA_W'(2));
        for (int k = 0; k < 5; k++) begin
            bins_to_send.push_back(make_bin(k, rand_magnitude(), rand_part(), rand_part(),
                                            k == 2));
        end

        // Neither side idles from here on.
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_phase(7, 16'hFFFF, 0);
        queue_traffic(250);
        set_phase(40, RST_GAIN_FLOOR, 2);
        queue_traffic(300);
        set_phase(1, 100, 4);
        queue_traffic(300);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
